// ===== hw/rtl/edf_pkg.sv =====
// Shared types and constants for the EDF day scheduler.
// No dependencies; compile first.
`default_nettype none

package edf_pkg;

  // Fixed width of the slot field on both channels
  localparam int SLOT_W = 6;

  // Request action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic insert;   // write the request's slot and mark it pending
    logic start;    // latch the day, reset the best-so-far
    logic scan;     // issue one read of the slot stores, advance the index
    logic publish;  // load the result register, retire the granted slot
  } edf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;  // the read being issued is for the last slot
    logic out_free;   // the result register can take a new result
  } edf_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/edf_in_if.sv =====
// Request channel: valid/ready handshake with insert and tick payload.
// Depends on edf_pkg.
`default_nettype none

interface edf_in_if
  import edf_pkg::*;
#(
  parameter int DAY_BITS = 24
) ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [SLOT_W-1:0]   event_slot;
  logic [DAY_BITS-1:0] release_day;
  logic [DAY_BITS-1:0] deadline_day;
  logic [DAY_BITS-1:0] today;

  modport source (
    output valid, action, event_slot, release_day, deadline_day, today,
    input  ready
  );
  modport sink (
    input  valid, action, event_slot, release_day, deadline_day, today,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/edf_out_if.sv =====
// Result channel: valid/ready handshake carrying one grant result.
// Depends on edf_pkg.
`default_nettype none

interface edf_out_if
  import edf_pkg::*;
#(
  parameter int DAY_BITS = 24
) ();
  logic                valid;
  logic                ready;
  logic                granted;
  logic [SLOT_W-1:0]   granted_slot;
  logic [DAY_BITS-1:0] assigned_day;

  modport source (
    output valid, granted, granted_slot, assigned_day,
    input  ready
  );
  modport sink (
    input  valid, granted, granted_slot, assigned_day,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/edf_ctrl.sv =====
// Sequencer for the EDF scheduler: accepts requests and steps the slot scan.
// Depends on edf_pkg; drives the command struct of edf_dp.
`default_nettype none

module edf_ctrl
  import edf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_action,
  output logic          in_ready,
  input  wire edf_sts_t sts,
  output edf_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_PUB   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_action == ACT_INSERT) begin
          cmd.insert = 1'b1;
        end else if (accept && in_action == ACT_TICK) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last read data is compared in this cycle
      ST_DRAIN: begin
        state_nxt = ST_PUB;
      end
      ST_PUB: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/edf_dp.sv =====
// Datapath for the EDF scheduler: slot stores, pending marks, scan compare
// and the result register. Depends on edf_pkg; commanded by edf_ctrl.
`default_nettype none

module edf_dp
  import edf_pkg::*;
#(
  parameter int SLOTS    = 64,
  parameter int DAY_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire edf_cmd_t            cmd,
  output edf_sts_t                 sts,
  input  wire logic [SLOT_W-1:0]   in_event_slot,
  input  wire logic [DAY_BITS-1:0] in_release_day,
  input  wire logic [DAY_BITS-1:0] in_deadline_day,
  input  wire logic [DAY_BITS-1:0] in_today,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic                     out_granted,
  output logic [SLOT_W-1:0]        out_granted_slot,
  output logic [DAY_BITS-1:0]      out_assigned_day
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Slot stores: one write and one registered read per cycle
  logic [DAY_BITS-1:0] rel_mem [SLOTS];
  logic [DAY_BITS-1:0] dl_mem  [SLOTS];
  logic [DAY_BITS-1:0] rel_q, dl_q;

  logic [SLOTS-1:0]    pend_r;
  logic [IDX_W-1:0]    cnt_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                rd_vld_r;
  logic [DAY_BITS-1:0] day_r;
  logic                found_r;
  logic [IDX_W-1:0]    best_r;
  logic [DAY_BITS-1:0] best_dl_r;

  logic                out_valid_r;
  logic                out_granted_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [DAY_BITS-1:0] out_day_r;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic                eligible;
  logic                take;

  // Drop inserts to slots beyond the table
  assign wr_en  = cmd.insert && (CMP_W'(in_event_slot) < SLOTS_C);
  assign wr_idx = IDX_W'(in_event_slot);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rel_mem[wr_idx] <= in_release_day;
      dl_mem[wr_idx]  <= in_deadline_day;
    end
    rel_q <= rel_mem[cnt_r];
    dl_q  <= dl_mem[cnt_r];
  end

  // Strict less-than keeps the lowest slot on equal deadlines
  assign eligible = rd_vld_r && pend_r[rd_idx_r] && (rel_q <= day_r);
  assign take     = eligible && (!found_r || (dl_q < best_dl_r));

  assign sts.scan_last = (cnt_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (wr_en) begin
        pend_r[wr_idx] <= 1'b1;
      end
      if (cmd.start) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else if (cmd.scan) begin
        cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
      end
      if (take) begin
        found_r <= 1'b1;
      end
      if (cmd.publish && found_r) begin
        pend_r[best_r] <= 1'b0;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (cmd.start) begin
      day_r <= in_today;
    end
    if (take) begin
      best_r    <= rd_idx_r;
      best_dl_r <= dl_q;
    end
    if (cmd.publish) begin
      out_granted_r <= found_r;
      out_slot_r    <= found_r ? SLOT_W'(best_r) : '0;
      out_day_r     <= found_r ? day_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_granted_slot = out_slot_r;
  assign out_assigned_day = out_day_r;

  a_no_insert_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.insert && (cmd.scan || rd_vld_r)))
    else $error("insert during slot scan");

  a_publish_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !rd_vld_r && !cmd.scan)
    else $error("result published while scan data in flight");

  a_publish_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before taken");

  a_grant_retires: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish && found_r |=> !pend_r[best_r])
    else $error("granted slot still pending");

endmodule

`default_nettype wire

// ===== hw/rtl/edf_interval_day_scheduler_unit.sv =====
// Top level of the EDF day scheduler: joins sequencer and datapath.
// Depends on edf_pkg, edf_in_if, edf_out_if, edf_ctrl and edf_dp.
`default_nettype none

// Earliest-deadline-first day scheduler. An insert request writes a slot's
// release and deadline days and marks it pending. A tick request scans every
// slot, one memory read per cycle, and grants the pending slot released on
// or before the tick's day with the smallest deadline (lowest slot on a tie),
// then returns one result. A tick occupies the block through the scan, a
// drain state and a publish state; the scan length is set by the single read
// port of the slot stores, and a tick stays longer only while an earlier
// result is still waiting on the result channel. Inserts to slots at or beyond
// SLOTS are dropped. The pending marks clear at reset; no clearing pass is needed.
module edf_interval_day_scheduler_unit
  import edf_pkg::*;
#(
  parameter int SLOTS    = 64,
  parameter int DAY_BITS = 24
) (
  input wire logic  clk,
  input wire logic  rst_n,
  edf_in_if.sink    in_chan,
  edf_out_if.source out_chan
);

  edf_cmd_t cmd;
  edf_sts_t sts;

  edf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  edf_dp #(
    .SLOTS    (SLOTS),
    .DAY_BITS (DAY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_event_slot    (in_chan.event_slot),
    .in_release_day   (in_chan.release_day),
    .in_deadline_day  (in_chan.deadline_day),
    .in_today         (in_chan.today),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_granted      (out_chan.granted),
    .out_granted_slot (out_chan.granted_slot),
    .out_assigned_day (out_chan.assigned_day)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for the EDF day scheduler: random and directed requests,
// a slot-table mirror that predicts each grant, and randomly stalled channels.
// Depends on edf_pkg, edf_in_if, edf_out_if and edf_interval_day_scheduler_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import edf_pkg::*;

  localparam int SLOTS        = 64;
  localparam int DAY_BITS     = 24;
  localparam int RANDOM_REQS  = 2000;
  localparam int GAP_MAX      = 14;
  localparam int HOLD_CYCLES  = 600;
  localparam int SETTLE       = 80;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef logic [DAY_BITS-1:0] day_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  typedef struct {
    logic  action;
    slot_t slot;
    day_t  rel;
    day_t  dl;
    day_t  today;
    int    gap;
    bit    drain;
  } request_t;

  typedef struct {
    logic  granted;
    slot_t slot;
    day_t  day;
  } grant_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  edf_in_if  #(.DAY_BITS(DAY_BITS)) in_chan ();
  edf_out_if #(.DAY_BITS(DAY_BITS)) out_chan ();

  edf_interval_day_scheduler_unit #(
    .SLOTS   (SLOTS),
    .DAY_BITS(DAY_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Mirror of the slot table
  day_t rel_mirror  [SLOTS];
  day_t dl_mirror   [SLOTS];
  bit   pend_mirror [SLOTS];

  request_t req_q[$];
  grant_t   due_grants[$];

  bit sender_gapless = 1'b0;
  int errors = 0;
  int n_insert = 0, n_tick = 0, n_grant = 0, n_idle_tick = 0;
  int n_in_stall = 0, n_sent = 0, n_results = 0, total_reqs = 0;
  int unsigned cycles = 0;

  // Update the mirror with one accepted request; a tick queues its grant.
  function automatic void book_request(request_t r);
    grant_t g;
    bit     found;
    int     best;
    day_t   best_dl;
    if (r.action == ACT_INSERT) begin
      if (int'(r.slot) < SLOTS) begin
        rel_mirror[r.slot]  = r.rel;
        dl_mirror[r.slot]   = r.dl;
        pend_mirror[r.slot] = 1'b1;
      end
      n_insert++;
      return;
    end
    n_tick++;
    found   = 1'b0;
    best    = 0;
    best_dl = '0;
    // strict less-than keeps the lowest slot on a deadline tie
    for (int i = 0; i < SLOTS; i++) begin
      if (pend_mirror[i] && rel_mirror[i] <= r.today) begin
        if (!found || dl_mirror[i] < best_dl) begin
          found   = 1'b1;
          best    = i;
          best_dl = dl_mirror[i];
        end
      end
    end
    if (found) begin
      pend_mirror[best] = 1'b0;
      g = '{1'b1, slot_t'(best), r.today};
      n_grant++;
    end else begin
      g = '{1'b0, slot_t'(0), day_t'(0)};
      n_idle_tick++;
    end
    due_grants = {due_grants, g};
  endfunction

  // Queue a request; fields the action does not use get random values.
  function automatic void add_request(logic act, slot_t s, day_t rel, day_t dl, day_t today,
                                      bit drain);
    request_t r;
    r.action = act;
    r.slot   = s;
    r.rel    = rel;
    r.dl     = dl;
    r.today  = today;
    if (act == ACT_INSERT) begin
      r.today = day_t'($urandom);
    end else begin
      r.slot = slot_t'($urandom);
      r.rel  = day_t'($urandom);
      r.dl   = day_t'($urandom);
    end
    r.gap   = sender_gapless ? 0 : $urandom_range(0, GAP_MAX);
    r.drain = drain;
    req_q = {req_q, r};
  endfunction

  initial begin
    day_t  base;
    day_t  rel;
    slot_t s;
    logic  act;
    bit    noise;
    bit    drain;
    in_chan.valid        = 1'b0;
    in_chan.action       = ACT_INSERT;
    in_chan.event_slot   = '0;
    in_chan.release_day  = '0;
    in_chan.deadline_day = '0;
    in_chan.today        = '0;
    out_chan.ready       = 1'b0;

    // empty table, then the day extremes
    add_request(ACT_TICK,   0,  0,            0,            0,            0);
    add_request(ACT_INSERT, 0,  0,            24'hFFFFFF,   0,            0);
    add_request(ACT_INSERT, 63, 24'hFFFFFF,   0,            0,            0);
    add_request(ACT_TICK,   0,  0,            0,            0,            0);
    add_request(ACT_TICK,   0,  0,            0,            24'hFFFFFE,   0);
    add_request(ACT_TICK,   0,  0,            0,            24'hFFFFFF,   0);
    // equal deadlines: lowest slot first
    add_request(ACT_INSERT, 5,  10,           100,          0,            0);
    add_request(ACT_INSERT, 3,  10,           100,          0,            0);
    add_request(ACT_INSERT, 40, 5,            100,          0,            0);
    add_request(ACT_TICK,   0,  0,            0,            10,           0);
    add_request(ACT_TICK,   0,  0,            0,            10,           0);
    add_request(ACT_TICK,   0,  0,            0,            10,           0);
    add_request(ACT_TICK,   0,  0,            0,            10,           0);
    // rewrite a pending slot with a later release
    add_request(ACT_INSERT, 7,  1,            50,           0,            0);
    add_request(ACT_INSERT, 7,  200,          20,           0,            0);
    add_request(ACT_TICK,   0,  0,            0,            100,          0);
    add_request(ACT_TICK,   0,  0,            0,            200,          0);
    // earlier deadline beats lower slot
    add_request(ACT_INSERT, 9,  0,            0,            0,            0);
    add_request(ACT_INSERT, 8,  0,            1,            0,            0);
    add_request(ACT_TICK,   0,  0,            0,            0,            0);
    add_request(ACT_TICK,   0,  0,            0,            0,            0);

    // Days move in a window around base so releases, ties and rewrites interact.
    base = day_t'($urandom_range(0, 1000));
    for (int k = 0; k < RANDOM_REQS; k++) begin
      sender_gapless = (k >= 300 && k < 500) || (k >= 1400 && k < 1600);
      drain = (k == 0 || k == 1000);
      if (k % 400 == 399)
        base = day_t'($urandom);
      noise = ($urandom_range(0, 9) == 0);
      act   = ($urandom_range(0, 99) < 45) ? ACT_TICK : ACT_INSERT;
      if (noise) begin
        add_request(act, slot_t'($urandom), day_t'($urandom), day_t'($urandom),
                    day_t'($urandom), drain);
      end else if (act == ACT_TICK) begin
        base = base + day_t'($urandom_range(0, 3));
        add_request(ACT_TICK, 0, 0, 0, base, drain);
      end else begin
        s   = ($urandom_range(0, 2) == 0) ? slot_t'($urandom_range(0, 7)) : slot_t'($urandom);
        rel = base + day_t'($urandom_range(0, 24)) - day_t'(4);
        add_request(ACT_INSERT, s, rel, rel + day_t'($urandom_range(0, 31)), 0, drain);
      end
    end
    total_reqs = req_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (!(n_sent == total_reqs && due_grants.size() == 0))
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d inserts and %0d ticks: %0d grants, %0d empty ticks.",
             n_insert, n_tick, n_grant, n_idle_tick);
    $display("Request channel stalled for %0d cycles; %0d mismatches.", n_in_stall, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Request driver
  request_t cur;
  bit       holding  = 1'b0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      holding  = 1'b0;
      gap_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        book_request(cur);
        n_sent++;
        holding = 1'b0;
      end else if (in_chan.valid) begin
        n_in_stall++;
      end
      // hold a draining request back until every grant has come out
      if (!holding && req_q.size() > 0 && !(req_q[0].drain && due_grants.size() > 0)) begin
        cur      = req_q.pop_front();
        holding  = 1'b1;
        gap_left = cur.gap;
      end
      if (holding && gap_left == 0) begin
        in_chan.valid        <= 1'b1;
        in_chan.action       <= cur.action;
        in_chan.event_slot   <= cur.slot;
        in_chan.release_day  <= cur.rel;
        in_chan.deadline_day <= cur.dl;
        in_chan.today        <= cur.today;
      end else begin
        in_chan.valid <= 1'b0;
        if (holding)
          gap_left--;
      end
    end
  end

  // Result monitor and checker
  int stall_left = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        n_results++;
        if (due_grants.size() == 0) begin
          $error("unexpected result: granted=%0d granted_slot=%0d assigned_day=%0d",
                 out_chan.granted, out_chan.granted_slot, out_chan.assigned_day);
          errors++;
        end else begin
          want = due_grants.pop_front();
          if (out_chan.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, out_chan.granted);
            errors++;
          end
          if (out_chan.granted_slot !== want.slot) begin
            $error("granted_slot: expected %0d, got %0d", want.slot, out_chan.granted_slot);
            errors++;
          end
          if (out_chan.assigned_day !== want.day) begin
            $error("assigned_day: expected %0d, got %0d", want.day, out_chan.assigned_day);
            errors++;
          end
        end
        stall_left = ((n_results >= 200 && n_results < 350) ||
                      (n_results >= 800 && n_results < 950)) ? 0 : $urandom_range(0, GAP_MAX);
        // long hold-off so the block backs up into the request channel
        if (n_results == 30 || n_results == 700)
          hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d of %0d requests sent.",
               n_sent, total_reqs);
      $display("FAILURE");
      $finish;
    end
  end

endmodule
